@@ hdl/tds_pkg.sv @@
// shared types, constants and the fixed step table of the tone sequencer
// no dependencies

package tds_pkg;

  localparam logic [3:0] IDLE_STEP = 4'd15;
  localparam logic [3:0] TABLE_LEN = 4'd11;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_ms;
    logic [3:0]  pattern_start;
  } tds_in_t;

  typedef struct packed {
    logic        tone_on;
    logic [10:0] tone_freq_hz;
    logic        step_applied;
    logic        is_idle;
  } tds_out_t;

  typedef struct packed {
    logic [10:0] dur;
    logic [10:0] hz;
    logic [3:0]  nxt;
  } tds_step_t;

  typedef struct packed {
    logic [3:0]  step_index;
    logic [31:0] deadline_ms;
    logic [10:0] drive_freq;
  } tds_state_t;

  function automatic tds_step_t tds_lookup(input logic [3:0] idx);
    tds_step_t s;
    case (idx)
      4'd0:    s = '{dur: 11'd0,    hz: 11'd0,    nxt: IDLE_STEP};
      4'd1:    s = '{dur: 11'd200,  hz: 11'd800,  nxt: 4'd5};
      4'd2:    s = '{dur: 11'd200,  hz: 11'd1200, nxt: 4'd6};
      4'd3:    s = '{dur: 11'd200,  hz: 11'd1200, nxt: 4'd7};
      4'd4:    s = '{dur: 11'd200,  hz: 11'd800,  nxt: 4'd8};
      4'd5:    s = '{dur: 11'd200,  hz: 11'd1200, nxt: 4'd0};
      4'd6:    s = '{dur: 11'd200,  hz: 11'd800,  nxt: 4'd0};
      4'd7:    s = '{dur: 11'd200,  hz: 11'd1600, nxt: 4'd0};
      4'd8:    s = '{dur: 11'd200,  hz: 11'd0,    nxt: 4'd9};
      4'd9:    s = '{dur: 11'd200,  hz: 11'd800,  nxt: 4'd10};
      4'd10:   s = '{dur: 11'd1000, hz: 11'd0,    nxt: 4'd4};
      default: s = '{dur: 11'd0,    hz: 11'd0,    nxt: IDLE_STEP};
    endcase
    return s;
  endfunction

endpackage

@@ hdl/tds_step_unit.sv @@
// combinational step logic: deadline compare, table lookup, two chained steps
// depends on tds_pkg

module tds_step_unit import tds_pkg::*; (
  input  tds_in_t    item_i,
  input  tds_state_t state_i,
  output tds_state_t state_o,
  output tds_out_t   result_o
);

  logic [3:0]  idx0, idx1, idx2;
  logic [31:0] dl0, dl1, dl2;
  logic [31:0] diff0, diff1;
  logic [10:0] freq1, freq2;
  logic        app0, app1;
  tds_step_t   s0, s1;

  always_comb begin
    // a start transfer reloads the index and arms the deadline at now
    idx0  = item_i.req_type ? item_i.pattern_start : state_i.step_index;
    dl0   = item_i.req_type ? item_i.now_ms : state_i.deadline_ms;

    // first step: deadline passed when the wrapped difference is non-negative
    diff0 = item_i.now_ms - dl0;
    app0  = (idx0 < TABLE_LEN) && !diff0[31];
    s0    = tds_lookup(idx0);
    idx1  = app0 ? s0.nxt : idx0;
    dl1   = app0 ? (item_i.now_ms + {21'd0, s0.dur}) : dl0;
    freq1 = app0 ? s0.hz : state_i.drive_freq;

    // second step only fires after a zero-duration step; the table never chains further
    diff1 = item_i.now_ms - dl1;
    app1  = app0 && (idx1 < TABLE_LEN) && !diff1[31];
    s1    = tds_lookup(idx1);
    idx2  = app1 ? s1.nxt : idx1;
    dl2   = app1 ? (item_i.now_ms + {21'd0, s1.dur}) : dl1;
    freq2 = app1 ? s1.hz : freq1;

    state_o.step_index    = idx2;
    state_o.deadline_ms   = dl2;
    state_o.drive_freq    = freq2;

    result_o.tone_on      = (freq2 != 11'd0);
    result_o.tone_freq_hz = freq2;
    result_o.step_applied = app0;
    result_o.is_idle      = (idx2 == IDLE_STEP);
  end

endmodule

@@ hdl/table_driven_tone_sequencer.sv @@
// top level of the table-driven tone sequencer: input register, step logic, result register
// depends on tds_pkg and tds_step_unit

// Usage
//   Input channel in_valid_i / in_stall_o / in_data_i carries tick and start items;
//   a transfer happens at a rising edge with valid high and stall low.
//   Output channel out_valid_o / out_stall_i / out_data_o returns exactly one result
//   per input item, in order.
//   An item taken into the input register passes through the step logic into the result register.
//   Throughput: one item per cycle while the receiver does not stall; the sequencer
//   state (step index, deadline, drive frequency) is updated in the same cycle the result
//   register loads, so the next item sees it straight away. The path is two table lookups
//   and two chained 32-bit add/compare steps.
//   Reset (rst_ni low, asynchronous): both channels empty, step index idle (15),
//   deadline 0, buzzer silent.
//   When the receiver stalls, the result holds; the input register takes one more item
//   if it is empty, then in_stall_o rises until the result moves.

module table_driven_tone_sequencer import tds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tds_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tds_out_t out_data_o
);

  logic       in_valid_q;
  tds_in_t    in_data_q;
  logic       out_valid_q;
  tds_out_t   out_data_q;
  tds_state_t state_q;
  tds_state_t state_d;
  tds_out_t   result_d;
  logic       advance;

  // stage moves when the result register is empty or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  tds_step_unit u_step (
    .item_i   (in_data_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.step_index  <= IDLE_STEP;
      state_q.deadline_ms <= 32'd0;
      state_q.drive_freq  <= 11'd0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // an accepted transfer lands in the input register
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_valid_q)
    else $error("accepted input not captured");

  // the reported idle flag agrees with the stored step index
  a_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_data_q.is_idle == (state_q.step_index == IDLE_STEP)))
    else $error("idle flag disagrees with step index");

  // reported frequency agrees with the stored drive frequency
  a_freq_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_data_q.tone_freq_hz == state_q.drive_freq))
    else $error("frequency disagrees with state");

  // the input stage only stalls while holding an item behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

endmodule

@@ test/tds_tone_checker.sv @@
// checker for the tone sequencer: watches both channels, predicts each result
// from its own copy of the step table and sequencer state, and counts mismatches
// depends on tds_pkg for the channel payload types and the idle/table constants

module tds_tone_checker import tds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  tds_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  tds_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  typedef struct packed {
    logic [15:0] dur_ms;
    logic [10:0] hz;
    logic [3:0]  nxt;
  } tone_step_t;

  // predicted sequencer state
  logic [3:0]  seq_idx;
  logic [31:0] seq_deadline;
  logic [10:0] seq_freq;

  tds_out_t pending_tones[$];
  tds_out_t want_r;
  tds_out_t pred_r;
  int       result_num;

  function automatic tone_step_t step_row(input logic [3:0] idx);
    tone_step_t row;
    case (idx)
      4'd1:    row = {16'd200, 11'd800, 4'd5};
      4'd2:    row = {16'd200, 11'd1200, 4'd6};
      4'd3:    row = {16'd200, 11'd1200, 4'd7};
      4'd4:    row = {16'd200, 11'd800, 4'd8};
      4'd5:    row = {16'd200, 11'd1200, 4'd0};
      4'd6:    row = {16'd200, 11'd800, 4'd0};
      4'd7:    row = {16'd200, 11'd1600, 4'd0};
      4'd8:    row = {16'd200, 11'd0, 4'd9};
      4'd9:    row = {16'd200, 11'd800, 4'd10};
      4'd10:   row = {16'd1000, 11'd0, 4'd4};
      default: row = {16'd0, 11'd0, IDLE_STEP};
    endcase
    return row;
  endfunction

  task automatic advance_sequence(input tds_in_t t, output tds_out_t r);
    tone_step_t  row;
    logic [31:0] lag;
    logic        applied;
    int          g;
    applied = 1'b0;
    if (t.req_type) begin
      seq_idx      = t.pattern_start;
      seq_deadline = t.now_ms;
    end
    // zero-duration steps chain; the loop bound covers the longest chain
    for (g = 0; g < 16; g++) begin
      lag = t.now_ms - seq_deadline;
      if (seq_idx < TABLE_LEN && !lag[31]) begin
        row          = step_row(seq_idx);
        seq_freq     = row.hz;
        seq_idx      = row.nxt;
        seq_deadline = t.now_ms + {16'd0, row.dur_ms};
        applied      = 1'b1;
      end
    end
    r.tone_on      = (seq_freq != 11'd0);
    r.tone_freq_hz = seq_freq;
    r.step_applied = applied;
    r.is_idle      = (seq_idx == IDLE_STEP);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < 100)
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               result_num, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_idx      = IDLE_STEP;
      seq_deadline = 32'd0;
      seq_freq     = 11'd0;
      pending_tones.delete();
      result_num   = 0;
      fail_count_o = 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_tones.size() == 0) begin
          report_mismatch("transfer with nothing outstanding", int'(out_data_i), 0);
        end else begin
          want_r = pending_tones.pop_front();
          if (out_data_i.tone_on !== want_r.tone_on)
            report_mismatch("tone_on", int'(out_data_i.tone_on), int'(want_r.tone_on));
          if (out_data_i.tone_freq_hz !== want_r.tone_freq_hz)
            report_mismatch("tone_freq_hz", int'(out_data_i.tone_freq_hz),
                            int'(want_r.tone_freq_hz));
          if (out_data_i.step_applied !== want_r.step_applied)
            report_mismatch("step_applied", int'(out_data_i.step_applied),
                            int'(want_r.step_applied));
          if (out_data_i.is_idle !== want_r.is_idle)
            report_mismatch("is_idle", int'(out_data_i.is_idle), int'(want_r.is_idle));
        end
        result_num++;
      end
      if (in_valid_i && !in_stall_i) begin
        advance_sequence(in_data_i, pred_r);
        pending_tones.push_back(pred_r);
      end
      pending_o <= pending_tones.size();
    end
  end

endmodule

@@ test/table_driven_tone_sequencer_tb.sv @@
// testbench top for the tone sequencer: clock, reset, directed and random
// tick/start items, random output stalls, and the final verdict
// depends on tds_pkg, table_driven_tone_sequencer and tds_tone_checker

module table_driven_tone_sequencer_tb;
  import tds_pkg::*;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tds_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tds_out_t out_data;
  int       fail_count;
  int       pending;

  bit          steady;
  int          sent;
  int          i;
  int          j;
  int          ticks;
  logic [31:0] clock_ms;
  logic [3:0]  pat;

  table_driven_tone_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tds_tone_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 14);
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic req, input logic [31:0] now_v, input logic [3:0] p);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {req, now_v, p};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    steady    = 1'b0;
    sent      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: idle tick, step 0 chain to idle, deadline boundary, every table start index
    send_item(REQ_TICK, 32'd0, 4'hA);
    send_item(REQ_START, 32'hFFFF_FFFF, 4'd0);
    send_item(REQ_START, 32'd100, 4'd1);
    send_item(REQ_TICK, 32'h8000_012C, 4'h5);   // exactly half range past: not due
    send_item(REQ_TICK, 32'd299, 4'd0);
    send_item(REQ_TICK, 32'h8000_012B, 4'd0);   // largest lag still counted as due
    send_item(REQ_TICK, 32'h8000_01F3, 4'd0);
    for (i = 2; i <= 10; i++)
      send_item(REQ_START, i * 1000, i[3:0]);
    // indexes 11 to 14 hold the tone but do not read as idle
    send_item(REQ_START, 32'd50000, 4'd3);
    send_item(REQ_START, 32'd50001, 4'd13);
    send_item(REQ_TICK, 32'd60000, 4'd0);
    send_item(REQ_START, 32'd60001, 4'd14);
    send_item(REQ_START, 32'd60002, 4'd11);
    send_item(REQ_START, 32'd60003, 4'd15);
    // deadline wraps past zero
    send_item(REQ_START, 32'hFFFF_FF80, 4'd4);
    send_item(REQ_TICK, 32'h0000_0048, 4'hF);

    while (sent < 1725) begin
      steady = (sent > 700 && sent < 1100);
      case ($urandom_range(0, 9))
        8: send_item(REQ_TICK, $urandom, 4'($urandom_range(0, 15)));
        9: send_item(REQ_START, $urandom, 4'($urandom_range(0, 15)));
        default: begin
          // a pattern start followed by a run of advancing ticks
          clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                                 : $urandom;
          pat = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 10));
          send_item(REQ_START, clock_ms, pat);
          ticks = $urandom_range(4, 30);
          for (j = 0; j < ticks; j++) begin
            case ($urandom_range(0, 19))
              0:       clock_ms = clock_ms - $urandom_range(1, 500);
              1, 2, 3: clock_ms = clock_ms + $urandom_range(0, 1200);
              default: clock_ms = clock_ms + $urandom_range(0, 250);
            endcase
            send_item(REQ_TICK, clock_ms, 4'($urandom_range(0, 15)));
          end
        end
      endcase
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tds_pkg.sv
hdl/tds_step_unit.sv
hdl/table_driven_tone_sequencer.sv
test/tds_tone_checker.sv
test/table_driven_tone_sequencer_tb.sv
